[rtl/bsm3d_pkg.sv]
package bsm3d_pkg;

   localparam int unsigned CoordWidth = 32;
   localparam int unsigned DiffWidth = 33;
   localparam int unsigned SumWidth = 68;
   localparam int unsigned RootWidth = 36;
   localparam int unsigned MagWidth = 64;
   localparam logic [31:0] StepLengthReset = 32'd1092;
   localparam logic [31:0] CollisionRadiusReset = 32'd327680;

   typedef enum logic [1:0] {
      OP_STEP = 2'd0,
      OP_SET = 2'd1,
      OP_PROBE = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic {
      CSR_STEP_LENGTH = 1'b0,
      CSR_COLLISION_RADIUS = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIFF,
      ST_SQUARE,
      ST_TEST,
      ST_ROOT,
      ST_SCALE_MUL,
      ST_DIVIDE,
      ST_APPLY,
      ST_DONE
   } state_type;

endpackage

[rtl/bsm3d_serial_mul.sv]
// Shift-and-add unsigned multiplier: one multiplier bit per cycle.
module bsm3d_serial_mul #(
   parameter int unsigned AWidth = 33,
   parameter int unsigned BWidth = 33
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [AWidth-1:0]          a,
   input  logic [BWidth-1:0]          b,
   output logic                       done,
   output logic [AWidth+BWidth-1:0]   product
);

   localparam int unsigned CountWidth = $clog2(BWidth + 1);

   logic [AWidth+BWidth-1:0] acc_ff, acc_in;
   logic [AWidth+BWidth-1:0] mcand_ff, mcand_in;
   logic [BWidth-1:0]        mplier_ff, mplier_in;
   logic [CountWidth-1:0]    count_ff, count_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;

   // One partial product is added per cycle while the multiplier shifts out.
   always_comb begin
      acc_in = acc_ff;
      mcand_in = mcand_ff;
      mplier_in = mplier_ff;
      count_in = count_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in = '0;
         mcand_in = {{BWidth{1'b0}}, a};
         mplier_in = b;
         count_in = CountWidth'(BWidth);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         count_in = count_ff - 1'b1;
         if (count_ff == CountWidth'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         count_ff <= count_in;
      end
      acc_ff <= acc_in;
      mcand_ff <= mcand_in;
      mplier_ff <= mplier_in;
   end

   assign done = done_ff;
   assign product = acc_ff;

endmodule

[rtl/bounded_step_move_toward_point_3d_core.sv]
// Set and unused items go straight to the result; a probe or a snapping step squares the
// limit and the offsets, and a step that moves also takes a square root and divides per axis.
// Flow: one item in flight; the next input can be taken from the cycle after the result
// register loads, while that result may still wait; a finished item holds in its last
// state until the result register is free. The serial multiplier, the square root and
// the restoring divider run one after another.
module bounded_step_move_toward_point_3d_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [31:0] point_x, [63:32] point_y, [95:64] point_z
   input  logic [95:0]  req_tdata,
   // [1:0] operation
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [31:0] position_x, [63:32] position_y, [95:64] position_z
   output logic [95:0]  rsp_tdata,
   // [0] arrived, [1] collides
   output logic [1:0]   rsp_tuser,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [31:0]  csr_data
);

   localparam int unsigned DivWidth = 96;
   localparam int unsigned DivCountWidth = 7;
   localparam int unsigned RootCountWidth = 6;

   bsm3d_pkg::state_type state_ff, state_in;

   logic [31:0] step_ff, radius_ff;
   logic signed [31:0] pos_ff [3];
   logic signed [31:0] pt_ff [3];
   bsm3d_pkg::op_type op_ff;
   logic [32:0] mag_ff [3];
   logic [2:0]  neg_ff;
   logic [1:0]  axis_ff, axis_in;
   logic [67:0] sum_ff, sum_in;
   logic [67:0] lim_ff, lim_in;
   logic        phase_ff, phase_in;
   logic        collides_ff, collides_in;
   logic        out_valid_ff;
   logic [95:0] out_data_ff;
   logic [1:0]  out_user_ff;

   // Square root state (bit-pair restoring method).
   logic [67:0] rad_ff, rad_in;
   logic [37:0] rem_ff, rem_in;
   logic [35:0] root_ff, root_in;
   logic [RootCountWidth-1:0] rcnt_ff, rcnt_in;

   // Divider state.
   logic [DivWidth-1:0] dividend_ff, dividend_in;
   logic [36:0] drem_ff, drem_in;
   logic [DivCountWidth-1:0] dcnt_ff, dcnt_in;

   // Shared serial multiplier.
   logic        mul_start;
   logic [32:0] mul_a, mul_b;
   logic        mul_done;
   logic [65:0] mul_p;

   bsm3d_serial_mul #(.AWidth(33), .BWidth(33)) u_mul (
      .clock(clock), .reset(reset), .start(mul_start),
      .a(mul_a), .b(mul_b), .done(mul_done), .product(mul_p)
   );

   logic req_fire, rsp_fire, mul_pending_ff, mul_pending_in, out_load;
   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign req_tready = (state_ff == bsm3d_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   // The finished item moves into the result register once that register is free.
   assign out_load = (state_ff == bsm3d_pkg::ST_DONE) && (!out_valid_ff || rsp_fire);

   logic [37:0] trial;
   logic [36:0] dshift;
   logic [32:0] diff [3];
   logic signed [32:0] dsigned [3];
   logic [31:0] move_mag;
   logic signed [32:0] new_pos;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         dsigned[k] = (op_ff == bsm3d_pkg::OP_PROBE) ?
            (33'(pos_ff[k]) - 33'(pt_ff[k])) : (33'(pt_ff[k]) - 33'(pos_ff[k]));
         diff[k] = dsigned[k][32] ? (33'd0 - dsigned[k]) : dsigned[k];
      end
      trial = {rem_ff[35:0], rad_ff[67:66]} - {root_ff, 2'b01};
      dshift = {drem_ff[35:0], dividend_ff[DivWidth-1]};
      move_mag = dividend_ff[31:0];
      new_pos = neg_ff[axis_ff] ? (33'(pos_ff[axis_ff]) - 33'({1'b0, move_mag}))
                                : (33'(pos_ff[axis_ff]) + 33'({1'b0, move_mag}));
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bsm3d_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_tuser == bsm3d_pkg::OP_STEP || req_tuser == bsm3d_pkg::OP_PROBE) begin
                  state_in = bsm3d_pkg::ST_DIFF;
               end else begin
                  state_in = bsm3d_pkg::ST_DONE;
               end
            end
         end
         bsm3d_pkg::ST_DIFF: state_in = bsm3d_pkg::ST_SQUARE;
         bsm3d_pkg::ST_SQUARE: begin
            if (mul_done && phase_ff && axis_ff == 2'd2) state_in = bsm3d_pkg::ST_TEST;
         end
         bsm3d_pkg::ST_TEST: begin
            if (op_ff == bsm3d_pkg::OP_PROBE) begin
               state_in = bsm3d_pkg::ST_DONE;
            end else if (sum_ff == '0 || sum_ff <= lim_ff) begin
               state_in = bsm3d_pkg::ST_DONE;
            end else begin
               state_in = bsm3d_pkg::ST_ROOT;
            end
         end
         bsm3d_pkg::ST_ROOT: begin
            if (rcnt_ff == RootCountWidth'(1)) state_in = bsm3d_pkg::ST_SCALE_MUL;
         end
         bsm3d_pkg::ST_SCALE_MUL: if (mul_done) state_in = bsm3d_pkg::ST_DIVIDE;
         bsm3d_pkg::ST_DIVIDE: begin
            if (dcnt_ff == DivCountWidth'(1)) state_in = bsm3d_pkg::ST_APPLY;
         end
         bsm3d_pkg::ST_APPLY: begin
            state_in = (axis_ff == 2'd2) ? bsm3d_pkg::ST_DONE : bsm3d_pkg::ST_SCALE_MUL;
         end
         bsm3d_pkg::ST_DONE: if (out_load) state_in = bsm3d_pkg::ST_IDLE;
         default: state_in = bsm3d_pkg::ST_IDLE;
      endcase
   end

   // Datapath control.
   always_comb begin
      axis_in = axis_ff;
      sum_in = sum_ff;
      lim_in = lim_ff;
      phase_in = phase_ff;
      collides_in = collides_ff;
      rad_in = rad_ff;
      rem_in = rem_ff;
      root_in = root_ff;
      rcnt_in = rcnt_ff;
      dividend_in = dividend_ff;
      drem_in = drem_ff;
      dcnt_in = dcnt_ff;
      mul_start = 1'b0;
      mul_pending_in = mul_pending_ff;
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         bsm3d_pkg::ST_IDLE: begin
            collides_in = 1'b0;
            axis_in = '0;
            sum_in = '0;
            phase_in = 1'b0;
         end
         bsm3d_pkg::ST_DIFF: begin
            // Square the limit first, then the three offsets.
            mul_start = 1'b1;
            mul_a = (op_ff == bsm3d_pkg::OP_PROBE) ? {1'b0, radius_ff} : {1'b0, step_ff};
            mul_b = mul_a;
            phase_in = 1'b0;
         end
         bsm3d_pkg::ST_SQUARE: begin
            if (mul_done) begin
               if (!phase_ff) begin
                  lim_in = 68'(mul_p);
                  phase_in = 1'b1;
               end else begin
                  sum_in = sum_ff + 68'(mul_p);
                  axis_in = axis_ff + 2'd1;
               end
               if (!(phase_ff && axis_ff == 2'd2)) begin
                  mul_start = 1'b1;
                  mul_a = phase_ff ? mag_ff[axis_ff + 2'd1] : mag_ff[axis_ff];
                  mul_b = mul_a;
               end else begin
                  axis_in = 2'd3;
               end
            end
         end
         bsm3d_pkg::ST_TEST: begin
            collides_in = (op_ff == bsm3d_pkg::OP_PROBE) && (sum_ff < lim_ff);
            rad_in = sum_ff;
            rem_in = '0;
            root_in = '0;
            rcnt_in = RootCountWidth'(34);
            axis_in = '0;
            mul_pending_in = 1'b1;
         end
         bsm3d_pkg::ST_ROOT: begin
            // One root bit per cycle from the next bit pair of the radicand.
            rad_in = rad_ff << 2;
            rcnt_in = rcnt_ff - 1'b1;
            if (!trial[37]) begin
               rem_in = trial;
               root_in = {root_ff[34:0], 1'b1};
            end else begin
               rem_in = {rem_ff[35:0], rad_ff[67:66]};
               root_in = {root_ff[34:0], 1'b0};
            end
         end
         bsm3d_pkg::ST_SCALE_MUL: begin
            if (mul_pending_ff) begin
               mul_start = 1'b1;
               mul_a = mag_ff[axis_ff];
               mul_b = {1'b0, step_ff};
               mul_pending_in = 1'b0;
            end
            if (mul_done) begin
               dividend_in = {30'd0, mul_p};
               drem_in = '0;
               dcnt_in = DivCountWidth'(DivWidth);
            end
         end
         bsm3d_pkg::ST_DIVIDE: begin
            // Restoring division, one quotient bit per cycle.
            dcnt_in = dcnt_ff - 1'b1;
            if (dshift >= {1'b0, root_ff}) begin
               drem_in = dshift - {1'b0, root_ff};
               dividend_in = {dividend_ff[DivWidth-2:0], 1'b1};
            end else begin
               drem_in = dshift;
               dividend_in = {dividend_ff[DivWidth-2:0], 1'b0};
            end
         end
         bsm3d_pkg::ST_APPLY: begin
            axis_in = axis_ff + 2'd1;
            mul_pending_in = 1'b1;
         end
         bsm3d_pkg::ST_DONE: ;
         default: ;
      endcase
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bsm3d_pkg::ST_IDLE;
         step_ff <= bsm3d_pkg::StepLengthReset;
         radius_ff <= bsm3d_pkg::CollisionRadiusReset;
         for (int k = 0; k < 3; k++) pos_ff[k] <= '0;
         out_valid_ff <= 1'b0;
         mul_pending_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mul_pending_ff <= mul_pending_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == bsm3d_pkg::CSR_STEP_LENGTH) step_ff <= csr_data;
            else radius_ff <= csr_data;
         end
         if (state_ff == bsm3d_pkg::ST_IDLE && req_fire && req_tuser == bsm3d_pkg::OP_SET) begin
            pos_ff[0] <= req_tdata[31:0];
            pos_ff[1] <= req_tdata[63:32];
            pos_ff[2] <= req_tdata[95:64];
         end
         if (state_ff == bsm3d_pkg::ST_TEST && op_ff == bsm3d_pkg::OP_STEP &&
             sum_ff <= lim_ff) begin
            for (int k = 0; k < 3; k++) pos_ff[k] <= pt_ff[k];
         end
         if (state_ff == bsm3d_pkg::ST_APPLY) pos_ff[axis_ff] <= new_pos[31:0];
         if (out_load) out_valid_ff <= 1'b1;
         else if (rsp_fire) out_valid_ff <= 1'b0;
      end
      if (req_fire) begin
         op_ff <= bsm3d_pkg::op_type'(req_tuser);
         pt_ff[0] <= req_tdata[31:0];
         pt_ff[1] <= req_tdata[63:32];
         pt_ff[2] <= req_tdata[95:64];
      end
      if (state_ff == bsm3d_pkg::ST_DIFF) begin
         for (int k = 0; k < 3; k++) begin
            mag_ff[k] <= diff[k];
            neg_ff[k] <= dsigned[k][32];
         end
      end
      if (out_load) begin
         out_data_ff <= {pos_ff[2], pos_ff[1], pos_ff[0]};
         out_user_ff <= {collides_ff, (pos_ff[0] == pt_ff[0]) && (pos_ff[1] == pt_ff[1]) &&
                         (pos_ff[2] == pt_ff[2])};
      end
      axis_ff <= axis_in;
      sum_ff <= sum_in;
      lim_ff <= lim_in;
      phase_ff <= phase_in;
      collides_ff <= collides_in;
      rad_ff <= rad_in;
      rem_ff <= rem_in;
      root_ff <= root_in;
      rcnt_ff <= rcnt_in;
      dividend_ff <= dividend_in;
      drem_ff <= drem_in;
      dcnt_ff <= dcnt_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = out_data_ff;
   assign rsp_tuser = out_user_ff;

   // A waiting result stays valid and unchanged until its transfer.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)))
      else $error("waiting result changed");
   // Work begins only from an accepted transfer.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == bsm3d_pkg::ST_IDLE && !req_fire) |=> state_ff == bsm3d_pkg::ST_IDLE)
      else $error("left idle without input");
   // The divisor is never zero when dividing.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == bsm3d_pkg::ST_DIVIDE |-> root_ff != '0)
      else $error("zero divisor");

endmodule

[test/bsm3d_checker.sv]
module bsm3d_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [95:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [95:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_index,
   input  logic [31:0] csr_data,
   output int          error_count,
   output int          pending_count,
   output int          result_count,
   output int          collide_count,
   output int          snap_count
);

   typedef struct packed {
      logic signed [31:0] pos_z;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_x;
      logic               collides;
      logic               arrived;
   } motion_result_type;

   logic        [31:0] step_len;
   logic        [31:0] radius;
   logic signed [31:0] pos [3];
   motion_result_type  expected_results [$];

   // Integer square root, floor, of a 68-bit value.
   function automatic logic [35:0] floor_sqrt(input logic [67:0] s);
      logic [35:0] r;
      logic [35:0] c;
      logic [71:0] sq;
      r = '0;
      for (int b = 35; b >= 0; b--) begin
         c = r | (36'd1 << b);
         sq = c * c;
         if (sq <= {4'd0, s}) r = c;
      end
      return r;
   endfunction

   // Apply one input transfer to the predicted state and form its result.
   function automatic motion_result_type predict_motion(input bsm3d_pkg::op_type op,
                                                        input logic [95:0] data);
      motion_result_type  res;
      logic signed [32:0] d [3];
      logic signed [31:0] p [3];
      logic        [32:0] mag;
      logic        [67:0] sq_len;
      logic        [67:0] rlim;
      logic        [35:0] len;
      logic        [64:0] prod;
      logic        [64:0] move;
      for (int k = 0; k < 3; k++) p[k] = data[32*k +: 32];
      sq_len = '0;
      res = '0;
      case (op)
         bsm3d_pkg::OP_STEP: begin
            for (int k = 0; k < 3; k++) begin
               d[k] = 33'(p[k]) - 33'(pos[k]);
               mag = d[k][32] ? 33'(-d[k]) : 33'(d[k]);
               sq_len += 68'(mag) * 68'(mag);
            end
            if (sq_len != 0) begin
               rlim = 68'(step_len) * 68'(step_len);
               if (sq_len <= rlim) begin
                  snap_count++;
                  for (int k = 0; k < 3; k++) pos[k] = p[k];
               end else begin
                  len = floor_sqrt(sq_len);
                  for (int k = 0; k < 3; k++) begin
                     mag = d[k][32] ? 33'(-d[k]) : 33'(d[k]);
                     prod = 65'(mag) * 65'(step_len);
                     move = prod / 65'(len);
                     pos[k] = d[k][32] ? pos[k] - 32'(move) : pos[k] + 32'(move);
                  end
               end
            end
         end
         bsm3d_pkg::OP_SET: begin
            for (int k = 0; k < 3; k++) pos[k] = p[k];
         end
         bsm3d_pkg::OP_PROBE: begin
            for (int k = 0; k < 3; k++) begin
               d[k] = 33'(pos[k]) - 33'(p[k]);
               mag = d[k][32] ? 33'(-d[k]) : 33'(d[k]);
               sq_len += 68'(mag) * 68'(mag);
            end
            rlim = 68'(radius) * 68'(radius);
            res.collides = (sq_len < rlim);
            if (res.collides) collide_count++;
         end
         default: ;
      endcase
      res.pos_x = pos[0];
      res.pos_y = pos[1];
      res.pos_z = pos[2];
      res.arrived = (pos[0] == p[0]) && (pos[1] == p[1]) && (pos[2] == p[2]);
      return res;
   endfunction

   assign pending_count = expected_results.size();

   // Track register writes, predict on input transfers, compare on result transfers.
   always @(posedge clock) begin
      motion_result_type want;
      int errs;
      errs = 0;
      if (reset) begin
         step_len <= bsm3d_pkg::StepLengthReset;
         radius <= bsm3d_pkg::CollisionRadiusReset;
         for (int k = 0; k < 3; k++) pos[k] = '0;
         expected_results.delete();
         error_count <= 0;
         result_count <= 0;
         collide_count = 0;
         snap_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (bsm3d_pkg::csr_index_type'(csr_index) == bsm3d_pkg::CSR_STEP_LENGTH)
               step_len <= csr_data;
            else radius <= csr_data;
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(predict_motion(bsm3d_pkg::op_type'(req_tuser),
                                                      req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            result_count <= result_count + 1;
            if (expected_results.size() == 0) begin
               $error("result transfer with no expectation waiting");
               errs++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata[31:0] !== want.pos_x) begin
                  $error("position_x expected %h got %h", want.pos_x, rsp_tdata[31:0]);
                  errs++;
               end
               if (rsp_tdata[63:32] !== want.pos_y) begin
                  $error("position_y expected %h got %h", want.pos_y, rsp_tdata[63:32]);
                  errs++;
               end
               if (rsp_tdata[95:64] !== want.pos_z) begin
                  $error("position_z expected %h got %h", want.pos_z, rsp_tdata[95:64]);
                  errs++;
               end
               if (rsp_tuser[0] !== want.arrived) begin
                  $error("arrived expected %b got %b", want.arrived, rsp_tuser[0]);
                  errs++;
               end
               if (rsp_tuser[1] !== want.collides) begin
                  $error("collides expected %b got %b", want.collides, rsp_tuser[1]);
                  errs++;
               end
            end
         end
         error_count <= error_count + errs;
      end
   end

endmodule

[test/tb_bounded_step_move_toward_point_3d_core.sv]
module tb_bounded_step_move_toward_point_3d_core;

   localparam int MaxCycles = 10_000_000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [95:0] req_tdata;
   logic [1:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [95:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [31:0] csr_data;
   int          error_count;
   int          pending_count;
   int          result_count;
   int          collide_count;
   int          snap_count;
   int          cycle_count;
   bit          hold_off;
   int          sent_count;
   logic signed [31:0] track [3];

   bounded_step_move_toward_point_3d_core dut (.*);

   bsm3d_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Global watchdog on cycle count.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MaxCycles) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int gap_length();
      if ($urandom_range(0, 2) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
      return $urandom_range(1, 4);
   endfunction

   // Result side backpressure, with one long hold-off on request.
   initial begin
      int n;
      rsp_tready = 1'b0;
      @(posedge clock iff !reset);
      forever begin
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (3000) @(posedge clock);
            hold_off = 1'b0;
         end
         n = ($urandom_range(0, 3) == 0) ? gap_length() : 0;
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
      end
   end

   // Random coordinate biased toward the tracked position, extremes and noise.
   function automatic logic [31:0] pick_coord(input int k);
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return ($urandom_range(0, 1) != 0) ? 32'h7fffffff : 32'h80000000;
         2, 3: return track[k] + $signed($urandom_range(0, 8191)) - 4096;
         4, 5: return track[k] + $signed($urandom_range(0, 2_000_000)) - 1_000_000;
         default: return $signed($urandom_range(0, 20_000_000)) - 10_000_000;
      endcase
   endfunction

   task automatic send_item(input bsm3d_pkg::op_type op, input logic [31:0] x,
                            input logic [31:0] y, input logic [31:0] z);
      int n;
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {z, y, x};
      @(posedge clock iff req_tready);
      sent_count++;
      if (op == bsm3d_pkg::OP_SET) begin
         track[0] = x;
         track[1] = y;
         track[2] = z;
      end
      n = gap_length();
      if (!hold_off && n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock iff pending_count == 0);
      repeat (500) @(posedge clock);
   endtask

   task automatic write_reg(input bsm3d_pkg::csr_index_type idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock iff csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_items(input int count);
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      bsm3d_pkg::op_type op;
      for (int i = 0; i < count; i++) begin
         x = pick_coord(0);
         y = pick_coord(1);
         z = pick_coord(2);
         case ($urandom_range(0, 15))
            0, 1, 2: op = bsm3d_pkg::OP_SET;
            3, 4, 5, 6: op = bsm3d_pkg::OP_PROBE;
            7: op = bsm3d_pkg::OP_NONE;
            default: op = bsm3d_pkg::OP_STEP;
         endcase
         send_item(op, x, y, z);
      end
   endtask

   // Stimulus: directed corners, then random phases across register settings.
   initial begin
      logic [31:0] steps [6];
      logic [31:0] radii [6];
      steps = '{32'd0, 32'hffffffff, 32'd65536, 32'd1092, 32'd300000, 32'd40};
      radii = '{32'hffffffff, 32'd0, 32'd65536, 32'd327680, 32'd9000000, 32'd5};
      reset = 1'b1;
      cycle_count = 0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = bsm3d_pkg::OP_NONE;
      csr_valid = 1'b0;
      csr_index = bsm3d_pkg::CSR_STEP_LENGTH;
      csr_data = '0;
      hold_off = 1'b0;
      sent_count = 0;
      for (int k = 0; k < 3; k++) track[k] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items at reset settings.
      send_item(bsm3d_pkg::OP_STEP, 0, 0, 0);
      send_item(bsm3d_pkg::OP_STEP, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
      send_item(bsm3d_pkg::OP_STEP, 32'd500, 32'd0, 32'd0);
      send_item(bsm3d_pkg::OP_PROBE, 32'd327680, 0, 0);
      send_item(bsm3d_pkg::OP_PROBE, 32'd327679, 0, 0);
      send_item(bsm3d_pkg::OP_SET, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
      send_item(bsm3d_pkg::OP_STEP, 32'h80000000, 32'h80000000, 32'h80000000);
      send_item(bsm3d_pkg::OP_PROBE, 32'h80000000, 32'h80000000, 32'h80000000);
      send_item(bsm3d_pkg::OP_NONE, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
      send_item(bsm3d_pkg::OP_NONE, 32'h12345678, 0, 32'hffffffff);
      send_item(bsm3d_pkg::OP_SET, 32'hffffffff, 32'h00010000, 32'h80000000);
      send_item(bsm3d_pkg::OP_STEP, 32'hfffff000, 32'h00012000, 32'h80000400);
      send_item(bsm3d_pkg::OP_STEP, $urandom(), $urandom(), $urandom());
      wait_idle();
      write_reg(bsm3d_pkg::CSR_STEP_LENGTH, 32'd0);
      send_item(bsm3d_pkg::OP_STEP, 32'd100000, 32'd5, 32'd7);
      send_item(bsm3d_pkg::OP_STEP, track[0], track[1], track[2]);
      wait_idle();

      // Long receiver hold-off while the sender keeps offering.
      hold_off = 1'b1;
      random_items(40);
      wait_idle();

      // Random phases, each under a different register setting.
      for (int ph = 0; ph < 12; ph++) begin
         write_reg(bsm3d_pkg::CSR_STEP_LENGTH, (ph < 6) ? steps[ph] : $urandom());
         write_reg(bsm3d_pkg::CSR_COLLISION_RADIUS,
                   (ph < 6) ? radii[ph] : $urandom_range(0, 1 << 24));
         random_items(140);
         wait_idle();
      end

      $display("Run covered %0d items, %0d results, %0d collisions, %0d snaps.",
               sent_count, result_count, collide_count, snap_count);
      $display("Steps, sets, probes and unused operations under 14 register settings.");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
